// ===== design/tsc_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tsc_pkg
// Shared types, constants and helpers for the TCP segment checksum block.
// ----------------------------------------------------------------------------
package tsc_pkg;

  localparam int QUEUE_DEPTH = 4;
  localparam int CFG_IDX_W   = 8;

  localparam logic [15:0] PROTO_TCP = 16'h0006;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SRC_ADDR = 8'd0,
    CFG_DST_ADDR = 8'd1
  } cfg_idx_t;

  // One queued word: a byte pair, or the padded final word with the length folded in.
  typedef struct packed {
    logic [15:0] word;
    logic        last;
    logic [15:0] len;
  } tsc_entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  // 16-bit ones' complement add with end-around carry.
  function automatic logic [15:0] oc_add16(input logic [15:0] a, input logic [15:0] b);
    logic [16:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[15:0] + {15'b0, s[16]};
  endfunction

endpackage
`default_nettype wire

// ===== design/tsc_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tsc_if
// Channel interfaces: byte input, checksum result and register writes.
// ----------------------------------------------------------------------------
interface tsc_in_if import tsc_pkg::*; ();
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface tsc_out_if import tsc_pkg::*; ();
  logic        valid;
  logic        ready;
  logic [15:0] checksum;
  logic [15:0] segment_length;

  modport source (output valid, output checksum, output segment_length, input ready);
  modport sink   (input valid, input checksum, input segment_length, output ready);
endinterface

interface tsc_cfg_if import tsc_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [31:0]          data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

// ===== design/tsc_cfg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tsc_cfg
// Address registers and the registered pseudo-header sum (addresses + protocol).
// ----------------------------------------------------------------------------
module tsc_cfg import tsc_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]          cfg_data,
  output logic [15:0]          psum
);

  logic [31:0] src_r;
  logic [31:0] dst_r;
  logic [15:0] psum_r;
  logic [15:0] psum_nxt;
  logic [18:0] raw;
  logic [16:0] fold1;

  assign cfg_ready = 1'b1;

  always_comb begin
    raw   = {3'b0, src_r[31:16]} + {3'b0, src_r[15:0]} + {3'b0, dst_r[31:16]}
          + {3'b0, dst_r[15:0]} + {3'b0, PROTO_TCP};
    fold1 = {1'b0, raw[15:0]} + {14'b0, raw[18:16]};
    psum_nxt = fold1[15:0] + {15'b0, fold1[16]};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_r  <= '0;
      dst_r  <= '0;
      psum_r <= PROTO_TCP;
    end else begin
      psum_r <= psum_nxt;
      if (cfg_valid) begin
        if (cfg_index == CFG_SRC_ADDR) src_r <= cfg_data;
        if (cfg_index == CFG_DST_ADDR) dst_r <= cfg_data;
      end
    end
  end

  assign psum = psum_r;

endmodule
`default_nettype wire

// ===== design/tsc_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tsc_front
// Accepts bytes, pairs them into big-endian words, counts the segment length.
// ----------------------------------------------------------------------------
module tsc_front import tsc_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] data_byte,
  input  logic       last_byte,
  input  q_stat_t    q_stat,
  output logic       push,
  output tsc_entry_t push_entry
);

  logic [7:0]  pend_r;
  logic        odd_r;
  logic [15:0] count_r;
  logic        accept;
  logic [15:0] cnt_inc;
  logic [15:0] word_pair;

  assign in_ready = !q_stat.full;
  assign accept   = in_valid && !q_stat.full;
  assign cnt_inc  = count_r + 16'd1;

  always_comb begin
    word_pair       = odd_r ? {pend_r, data_byte} : {data_byte, 8'h00};
    push            = accept && (odd_r || last_byte);
    push_entry.last = last_byte;
    push_entry.len  = cnt_inc;
    // final word carries the length word of the pseudo-header
    push_entry.word = last_byte ? oc_add16(word_pair, cnt_inc) : word_pair;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      odd_r   <= 1'b0;
      count_r <= '0;
    end else if (accept) begin
      if (last_byte) begin
        odd_r   <= 1'b0;
        count_r <= '0;
      end else begin
        odd_r   <= !odd_r;
        count_r <= cnt_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) pend_r <= data_byte;
  end

endmodule
`default_nettype wire

// ===== design/tsc_queue.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tsc_queue
// Small FIFO of word entries between the front and the back.
// ----------------------------------------------------------------------------
module tsc_queue import tsc_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  input  tsc_entry_t push_entry,
  input  logic       pop,
  output tsc_entry_t head,
  output q_stat_t    q_stat
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  tsc_entry_t    mem [DEPTH];
  logic [PW-1:0] wr_ptr_r;
  logic [PW-1:0] rd_ptr_r;
  logic [CW-1:0] cnt_r;

  assign q_stat.full  = (cnt_r == FULL_CNT);
  assign q_stat.empty = (cnt_r == '0);
  assign head         = mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr_r] <= push_entry;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) wr_ptr_r <= (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + PW'(1);
      if (pop)  rd_ptr_r <= (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + PW'(1);
      if (push && !pop)      cnt_r <= cnt_r + CW'(1);
      else if (pop && !push) cnt_r <= cnt_r - CW'(1);
    end
  end

endmodule
`default_nettype wire

// ===== design/tsc_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tsc_back
// Ones' complement accumulator and result register.
// ----------------------------------------------------------------------------
module tsc_back import tsc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  tsc_entry_t  head,
  input  q_stat_t     q_stat,
  input  logic [15:0] psum,
  output logic        pop,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] checksum,
  output logic [15:0] segment_length
);

  logic [15:0] acc_r;
  logic        out_valid_r;
  logic [15:0] chk_r;
  logic [15:0] len_r;
  logic        slot_free;
  logic [17:0] raw;
  logic [16:0] fold1;
  logic [15:0] total;

  assign slot_free = !out_valid_r || out_ready;
  assign pop       = !q_stat.empty && (!head.last || slot_free);

  always_comb begin
    raw   = {2'b0, acc_r} + {2'b0, head.word} + (head.last ? {2'b0, psum} : 18'd0);
    fold1 = {1'b0, raw[15:0]} + {15'b0, raw[17:16]};
    total = fold1[15:0] + {15'b0, fold1[16]};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (pop) acc_r <= head.last ? 16'd0 : total;
      if (pop && head.last) out_valid_r <= 1'b1;
      else if (out_ready)   out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && head.last) begin
      chk_r <= ~total;
      len_r <= head.len;
    end
  end

  assign out_valid      = out_valid_r;
  assign checksum       = chk_r;
  assign segment_length = len_r;

endmodule
`default_nettype wire

// ===== design/tcp_segment_checksum.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tcp_segment_checksum
// TCP checksum over a byte stream with the IPv4 pseudo-header.
// ----------------------------------------------------------------------------
// Usage:
//   in_s   : one segment byte per item, header first; last_byte marks the end.
//   out_s  : one item per segment: checksum (first sent byte in 15:8) and
//            segment_length (bytes counted, modulo 65536).
//   cfg_s  : index 0 = source address, 1 = destination address; other
//            indexes are ignored. Always ready. Write only while idle.
// Throughput: one byte per cycle while the queue has room, set by the byte-wide input.
// Path: the last byte's word enters the queue when accepted; the result
//   register loads when that entry is popped, later while earlier entries
//   still wait in the queue or an earlier result is still pending.
// Reset: addresses, byte pairing, length count, queue and accumulator clear; no result pending.
// Stall: a pending result holds while out_s.ready is low; word entries
//   keep draining into the accumulator, and only a final entry waits, so
//   in_s.ready drops once the queue fills.
// ----------------------------------------------------------------------------
module tcp_segment_checksum import tsc_pkg::*; #(
  parameter int QUEUE_DEPTH_P = QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst_n,
  tsc_in_if.sink           in_s,
  tsc_out_if.source        out_s,
  tsc_cfg_if.sink          cfg_s
);

  q_stat_t     q_stat;
  logic        push;
  logic        pop;
  tsc_entry_t  push_entry;
  tsc_entry_t  head;
  logic [15:0] psum;

  tsc_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_s.valid),
    .cfg_ready (cfg_s.ready),
    .cfg_index (cfg_s.index),
    .cfg_data  (cfg_s.data),
    .psum      (psum)
  );

  tsc_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_s.valid),
    .in_ready   (in_s.ready),
    .data_byte  (in_s.data_byte),
    .last_byte  (in_s.last_byte),
    .q_stat     (q_stat),
    .push       (push),
    .push_entry (push_entry)
  );

  tsc_queue #(.DEPTH(QUEUE_DEPTH_P)) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .q_stat     (q_stat)
  );

  tsc_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .head           (head),
    .q_stat         (q_stat),
    .psum           (psum),
    .pop            (pop),
    .out_valid      (out_s.valid),
    .out_ready      (out_s.ready),
    .checksum       (out_s.checksum),
    .segment_length (out_s.segment_length)
  );

endmodule
`default_nettype wire

// ===== design/tsc_checker.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tsc_checker
// Port-level checks on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
module tsc_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [15:0] checksum,
  input logic [15:0] segment_length
);

  // stalled result stays
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(checksum) && $stable(segment_length))
    else $error("result changed while stalled");

  // no result straight out of reset
  a_rst_quiet: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_valid)
    else $error("result valid right after reset");

  // pseudo-header protocol word keeps the sum nonzero
  a_chk_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> checksum != 16'hFFFF)
    else $error("checksum of all ones");

endmodule

bind tcp_segment_checksum tsc_checker u_tsc_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .out_valid      (out_s.valid),
  .out_ready      (out_s.ready),
  .checksum       (out_s.checksum),
  .segment_length (out_s.segment_length)
);
`default_nettype wire

// ===== bench/tcp_segment_checksum_tb.sv =====
// ----------------------------------------------------------------------------
// tcp_segment_checksum_tb
// Streams TCP segments byte by byte through the checksum block and checks
// every checksum and length result against a bit-exact software predictor.
// A short directed run covers one-byte, odd-length and zero-checksum
// segments, unknown register indexes and an address change inside a
// segment. Random segments then follow under several address settings,
// with random stalls on both channels and a long receiver hold-off.
// ----------------------------------------------------------------------------
module tcp_segment_checksum_tb;
  import tsc_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int LATENCY = 2;
  localparam int HOLD_CYCLES = 300;
  localparam int PHASE_ITEMS = 250;
  localparam int NUM_PHASES = 6;
  localparam logic [CFG_IDX_W-1:0] CFG_UNKNOWN_IDX = 8'hFF;

  typedef enum int {FILL_RANDOM, FILL_ONES, FILL_ZEROS} fill_t;

  typedef struct packed {
    logic [15:0] checksum;
    logic [15:0] seg_len;
  } seg_result_t;

  class segment_checksum_board;
    logic [31:0] src_addr;
    logic [31:0] dst_addr;
    logic [31:0] word_sum;
    logic [7:0]  held_byte;
    bit          have_high;
    logic [15:0] byte_cnt;
    seg_result_t awaited[$];
    int          fail_count;

    function new();
      src_addr  = '0;
      dst_addr  = '0;
      word_sum  = '0;
      held_byte = '0;
      have_high = 1'b0;
      byte_cnt  = '0;
      fail_count = 0;
    endfunction

    function logic [31:0] ones_add(logic [31:0] a, logic [31:0] b);
      logic [32:0] t;
      t = {1'b0, a} + {1'b0, b};
      return t[31:0] + {31'b0, t[32]};
    endfunction

    function logic [15:0] fold(logic [31:0] s);
      while (s[31:16] != 16'h0) s = {16'h0, s[15:0]} + {16'h0, s[31:16]};
      return s[15:0];
    endfunction

    function void flag(string msg);
      fail_count++;
      if (fail_count <= 10) $display("%0t: %s", $realtime, msg);
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] value);
      case (idx)
        CFG_SRC_ADDR: src_addr = value;
        CFG_DST_ADDR: dst_addr = value;
        default: ;
      endcase
    endfunction

    function void note_byte(logic [7:0] b, logic last);
      logic [31:0] s;
      seg_result_t r;
      if (have_high) begin
        word_sum  = ones_add(word_sum, {16'h0, held_byte, b});
        held_byte = '0;
        have_high = 1'b0;
      end else begin
        held_byte = b;
        have_high = 1'b1;
      end
      byte_cnt = byte_cnt + 16'd1;
      if (last) begin
        s = word_sum;
        if (have_high) s = ones_add(s, {16'h0, held_byte, 8'h00});
        s = ones_add(s, {16'h0, src_addr[31:16]});
        s = ones_add(s, {16'h0, src_addr[15:0]});
        s = ones_add(s, {16'h0, dst_addr[31:16]});
        s = ones_add(s, {16'h0, dst_addr[15:0]});
        s = ones_add(s, {16'h0, PROTO_TCP});
        s = ones_add(s, {16'h0, byte_cnt});
        r.checksum = ~fold(s);
        r.seg_len  = byte_cnt;
        awaited.push_back(r);
        word_sum  = '0;
        held_byte = '0;
        have_high = 1'b0;
        byte_cnt  = '0;
      end
    endfunction

    function void check_result(logic [15:0] cs, logic [15:0] len);
      seg_result_t e;
      if (awaited.size() == 0) begin
        flag($sformatf("unexpected result checksum=%h length=%0d", cs, len));
        return;
      end
      e = awaited.pop_front();
      if (cs !== e.checksum)
        flag($sformatf("checksum mismatch: expected %h got %h", e.checksum, cs));
      if (len !== e.seg_len)
        flag($sformatf("length mismatch: expected %0d got %0d", e.seg_len, len));
    endfunction

    function int outstanding();
      return awaited.size();
    endfunction

    function void close_out();
      if (awaited.size() != 0)
        flag($sformatf("%0d results never arrived", awaited.size()));
    endfunction
  endclass

  logic clk;
  logic rst_n;

  tsc_in_if  in_if();
  tsc_out_if out_if();
  tsc_cfg_if cfg_if();

  tcp_segment_checksum dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_s  (in_if.sink),
    .out_s (out_if.source),
    .cfg_s (cfg_if.sink)
  );

  segment_checksum_board board;
  bit tx_steady;
  bit rx_steady;
  bit hold_req;
  int sent_items;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #3_000_000;
    $display("Regression FAIL");
    $finish;
  end

  function int idle_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function int pick_length();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 8);
    if (r < 95) return $urandom_range(9, 64);
    return $urandom_range(65, 300);
  endfunction

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_if.valid && in_if.ready) board.note_byte(in_if.data_byte, in_if.last_byte);
      if (out_if.valid && out_if.ready)
        board.check_result(out_if.checksum, out_if.segment_length);
      if (cfg_if.valid && cfg_if.ready) board.set_reg(cfg_if.index, cfg_if.data);
    end
  end

  // result receiver
  initial begin
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_if.ready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
        out_if.ready = 1'b1;
      end else if (!rx_steady && $urandom_range(0, 3) == 0) begin
        out_if.ready = 1'b0;
        repeat (idle_gap() + 1) @(negedge clk);
        out_if.ready = 1'b1;
      end else begin
        out_if.ready = 1'b1;
      end
    end
  end

  // all tasks start and end at a falling edge
  task send_byte(input logic [7:0] b, input logic last);
    int gap;
    gap = tx_steady ? 0 : idle_gap();
    if (gap > 0) begin
      in_if.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_if.valid     = 1'b1;
    in_if.data_byte = b;
    in_if.last_byte = last;
    do @(posedge clk); while (!in_if.ready);
    @(negedge clk);
    sent_items++;
  endtask

  task send_segment(input int len, input fill_t fill);
    logic [7:0] b;
    for (int i = 0; i < len; i++) begin
      case (fill)
        FILL_ONES:  b = 8'hFF;
        FILL_ZEROS: b = 8'h00;
        default:    b = 8'($urandom_range(0, 255));
      endcase
      send_byte(b, i == len - 1);
    end
  endtask

  task wait_quiet();
    in_if.valid = 1'b0;
    while (board.outstanding() != 0) @(negedge clk);
    repeat (LATENCY + 2) @(negedge clk);
  endtask

  task cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] value);
    cfg_if.valid = 1'b1;
    cfg_if.index = idx;
    cfg_if.data  = value;
    do @(posedge clk); while (!cfg_if.ready);
    @(negedge clk);
    cfg_if.valid = 1'b0;
  endtask

  task set_addresses(input logic [31:0] src, input logic [31:0] dst);
    wait_quiet();
    cfg_write(CFG_SRC_ADDR, src);
    cfg_write(CFG_DST_ADDR, dst);
  endtask

  task random_segments(input int budget);
    int start;
    int r;
    fill_t fill;
    start = sent_items;
    while (sent_items - start < budget) begin
      r = $urandom_range(0, 19);
      fill = (r == 0) ? FILL_ONES : (r == 1) ? FILL_ZEROS : FILL_RANDOM;
      send_segment(pick_length(), fill);
    end
  endtask

  initial begin
    logic [31:0] src;
    logic [31:0] dst;
    board = new();
    tx_steady = 1'b0;
    rx_steady = 1'b0;
    hold_req  = 1'b0;
    sent_items = 0;
    rst_n = 1'b0;
    in_if.valid = 1'b0;
    in_if.data_byte = '0;
    in_if.last_byte = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.index = '0;
    cfg_if.data  = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed: addresses at reset value
    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b1);
    send_byte(8'hFF, 1'b0);        // sums to all ones: zero checksum
    send_byte(8'hF7, 1'b1);
    send_byte(8'h12, 1'b0);
    send_byte(8'h34, 1'b0);
    send_byte(8'h56, 1'b1);
    set_addresses(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_segment(4, FILL_ONES);
    wait_quiet();
    cfg_write(CFG_UNKNOWN_IDX, 32'h1234_5678);
    send_byte(8'hA5, 1'b1);
    // address change inside a segment
    send_byte(8'h01, 1'b0);
    send_byte(8'h02, 1'b0);
    send_byte(8'h03, 1'b0);
    set_addresses(32'hC0A8_0001, 32'h0A00_0002);
    send_byte(8'h04, 1'b1);
    send_byte(8'h80, 1'b0);
    send_byte(8'h7F, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h01, 1'b1);

    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      case (phase)
        0: begin src = 32'h0;         dst = 32'hFFFF_FFFF; end
        1: begin src = 32'hFFFF_FFFF; dst = 32'h0;         end
        4: begin src = 32'hFFFF_FFFF; dst = 32'hFFFF_FFFF; end
        default: begin src = $urandom; dst = $urandom; end
      endcase
      set_addresses(src, dst);
      tx_steady = (phase == 1);
      rx_steady = (phase == 1);
      if (phase == 4)
        cfg_write(CFG_IDX_W'(int'(CFG_DST_ADDR) + 1 + $urandom_range(0, 253)), $urandom);
      if (phase == 2) begin
        // receiver holds off while short segments pile up
        hold_req = 1'b1;
        for (int i = 0; i < 16; i++) send_segment($urandom_range(1, 2), FILL_RANDOM);
      end
      if (phase == 3) begin
        random_segments(PHASE_ITEMS / 2);
        wait_quiet();
      end
      random_segments(PHASE_ITEMS - (phase == 3 ? PHASE_ITEMS / 2 : 0));
    end

    set_addresses($urandom, $urandom);
    random_segments(20);

    in_if.valid = 1'b0;
    while (board.outstanding() != 0) @(negedge clk);
    repeat (LATENCY + 6) @(negedge clk);
    board.close_out();
    if (board.fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
